// File: rtl/core/cpr_pkg.sv
`default_nettype none

package cpr_pkg;

    // Reflected CRC-8 polynomial as applied before each right shift
    localparam logic [7:0] CRC_POLY = 8'h91;

    // Receive phases
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Packet types
    localparam logic [1:0] KIND_MODE = 2'd1;
    localparam logic [1:0] KIND_GAIN = 2'd2;
    localparam logic [1:0] KIND_SET  = 2'd3;

    // Operating mode classes
    localparam logic [1:0] MODE_SAFE  = 2'd1;
    localparam logic [1:0] MODE_PANIC = 2'd2;

    // Event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_MODE_OK  = 3'd1;
    localparam logic [2:0] EV_GAIN_OK  = 3'd2;
    localparam logic [2:0] EV_SET_OK   = 3'd3;
    localparam logic [2:0] EV_CRC_FAIL = 3'd4;
    localparam logic [2:0] EV_IGNORED  = 3'd5;
    localparam logic [2:0] EV_BAD_TYPE = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [1:0] mode_class;
    } t_in;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] mode_request;
        logic [7:0] toggle_request;
        logic [7:0] gain_p;
        logic [7:0] gain_p1;
        logic [7:0] gain_p2;
        logic [7:0] yaw_target;
        logic [7:0] pitch_target;
        logic [7:0] roll_target;
        logic [7:0] lift_target;
    } t_out;

    typedef logic [3:0][7:0] t_payload;

    // What the parser reports for the byte being taken
    typedef struct packed {
        logic [2:0] ev;
        t_payload   payload;
    } t_parse_res;

    // Parser state, exposed for checking
    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] kind;
        logic [2:0] left;
    } t_parse_st;

    // One byte through the CRC, one bit per step
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = c ^ CRC_POLY;
            end
            c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cpr_parser.sv
`default_nettype none

module cpr_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic [7:0]          i_byte,
    input  wire logic [1:0]          i_mode,
    input  wire logic [7:0]          i_header,
    output cpr_pkg::t_parse_res      o_res,
    output cpr_pkg::t_parse_st       o_status
);
    import cpr_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [1:0] r_kind, n_kind;
    logic [2:0] r_left, n_left;
    logic [7:0] r_crc, n_crc;
    t_payload   r_payload;
    logic       n_pay_we;
    logic [2:0] w_idx;
    logic [7:0] w_crc_body;
    logic [2:0] n_ev;
    logic       w_panic, w_safe;

    assign w_panic    = (i_mode == MODE_PANIC);
    assign w_safe     = (i_mode == MODE_SAFE);
    assign w_idx      = {1'b0, r_kind} + 3'd2 - r_left;
    assign w_crc_body = crc8_step(r_crc, i_byte);

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_left   = r_left;
        n_crc    = r_crc;
        n_pay_we = 1'b0;
        n_ev     = EV_NONE;
        unique case (r_phase)
            PH_TYPE: begin
                if (i_byte >= 8'd1 && i_byte <= 8'd3) begin
                    n_kind  = i_byte[1:0];
                    n_left  = {1'b0, i_byte[1:0]} + 3'd2;
                    n_crc   = crc8_step(r_crc, i_byte);
                    n_phase = PH_BODY;
                end else begin
                    n_ev    = EV_BAD_TYPE;
                    n_phase = PH_HUNT;
                end
            end
            PH_BODY: begin
                n_crc = w_crc_body;
                if (r_left > 3'd1) begin
                    n_pay_we = 1'b1;
                    n_left   = r_left - 3'd1;
                end else begin
                    n_left  = 3'd0;
                    n_phase = PH_HUNT;
                    // mode check only after a good residue
                    if (w_crc_body != 8'd0) begin
                        n_ev = EV_CRC_FAIL;
                    end else if (r_kind == KIND_MODE) begin
                        n_ev = w_panic ? EV_IGNORED : EV_MODE_OK;
                    end else if (w_panic || w_safe) begin
                        n_ev = EV_IGNORED;
                    end else if (r_kind == KIND_GAIN) begin
                        n_ev = EV_GAIN_OK;
                    end else begin
                        n_ev = EV_SET_OK;
                    end
                end
            end
            default: begin
                // hunting, and the unused phase code
                n_phase = PH_HUNT;
                if (i_byte == i_header) begin
                    n_crc   = crc8_step(8'd0, i_byte);
                    n_phase = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_kind  <= 2'd0;
            r_left  <= 3'd0;
            r_crc   <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && n_pay_we) begin
            r_payload[w_idx[1:0]] <= i_byte;
        end
    end

    assign o_res.ev      = n_ev;
    assign o_res.payload = r_payload;

    assign o_status.phase = r_phase;
    assign o_status.kind  = r_kind;
    assign o_status.left  = r_left;

endmodule

`default_nettype wire

// File: rtl/core/command_packet_receiver.sv
`default_nettype none

// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_in  (t_in: rx_byte, mode_class)
// out       output     o_out_valid / i_out_ready    o_out (t_out: event_res, held bytes)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_data (header byte)
//
// One item in, one item out. An item taken at an edge has its result in the
// output register after that same edge, and one item can be taken every
// cycle while o_in_ready is high; the CRC byte step and the phase logic
// sit between the parser state and the output register.
// o_in_ready is high while the output register is empty or being emptied,
// so a stalled consumer stalls the input after exactly one held result.
// Reset (synchronous, active low) puts the parser in hunt, clears the held
// bytes and the header byte, and empties the output register.

module command_packet_receiver (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cpr_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output cpr_pkg::t_out      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [7:0]    i_cfg_data
);
    import cpr_pkg::*;

    logic             r_out_valid;
    logic [2:0]       r_event;
    logic [8:0][7:0]  r_held, n_held;
    logic [7:0]       r_header;
    logic             w_in_acc;
    t_parse_res       w_res;
    t_parse_st        w_st;

    // Accept a new item whenever the result slot is free or drains this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    cpr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_in_acc),
        .i_byte   (i_in.rx_byte),
        .i_mode   (i_in.mode_class),
        .i_header (r_header),
        .o_res    (w_res),
        .o_status (w_st)
    );

    // Copy the collected payload into the held bytes on an accepted packet
    always_comb begin
        n_held = r_held;
        unique case (w_res.ev)
            EV_MODE_OK: begin
                n_held[0] = w_res.payload[0];
                n_held[1] = w_res.payload[1];
            end
            EV_GAIN_OK: begin
                n_held[2] = w_res.payload[0];
                n_held[3] = w_res.payload[1];
                n_held[4] = w_res.payload[2];
            end
            EV_SET_OK: begin
                n_held[5] = w_res.payload[0];
                n_held[6] = w_res.payload[1];
                n_held[7] = w_res.payload[2];
                n_held[8] = w_res.payload[3];
            end
            default: begin
                // no update: hold
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 8'd0;
        end else if (i_cfg_valid) begin
            r_header <= i_cfg_data;
        end
    end

    // Held bytes only move on an accepted item, which also loads the output
    // register, so they always match the item on display.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_event     <= EV_NONE;
            r_held      <= '0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
            r_event     <= w_res.ev;
            r_held      <= n_held;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out.event_res      = r_event;
    assign o_out.mode_request   = r_held[0];
    assign o_out.toggle_request = r_held[1];
    assign o_out.gain_p         = r_held[2];
    assign o_out.gain_p1        = r_held[3];
    assign o_out.gain_p2        = r_held[4];
    assign o_out.yaw_target     = r_held[5];
    assign o_out.pitch_target   = r_held[6];
    assign o_out.roll_target    = r_held[7];
    assign o_out.lift_target    = r_held[8];

    // In the body the remaining byte count stays within one to five
    a_body_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_st.phase == PH_BODY) |-> (w_st.left != 3'd0 && w_st.left <= 3'd5))
        else $error("body phase with bad byte count");

    // A packet body always has a valid type behind it
    a_body_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_st.phase == PH_BODY) |-> (w_st.kind != 2'd0))
        else $error("body phase with no packet type");

    // Held bytes change only after an item that completed a good packet
    a_held_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_acc && (w_res.ev == EV_MODE_OK || w_res.ev == EV_GAIN_OK
                       || w_res.ev == EV_SET_OK)) |=> $stable(r_held))
        else $error("held bytes changed without an accepted packet");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cpr_pkg::*;

    // Mode classes the package leaves unnamed
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int BYTES_PER_PHASE  = 350;
    localparam int MAX_REPORTS      = 10;
    localparam int NUM_DIR_ROWS     = 8;

    // One directed row: a lone noise byte, or a header and a type byte, then for
    // a known type the payload taken from body (low byte first) and a CRC byte.
    // The event of the last byte sent for the row is typed in.
    typedef struct packed {
        logic       is_noise;
        logic [7:0] lead;
        logic [31:0] body;
        logic       crc_good;
        logic [1:0] mode;
        logic [2:0] ev;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    // Typed-in event that travels alongside the item being offered
    logic        drv_ev_known;
    logic [2:0]  drv_ev;

    // Receiver copy: header register, parser state, payload and held bytes
    logic [7:0]  hdr_model;
    logic [1:0]  rx_phase;
    logic [1:0]  pkt_kind;
    logic [2:0]  bytes_left;
    logic [7:0]  crc_acc;
    logic [7:0]  payload_buf [4];
    logic [7:0]  held_val [9];

    t_out        pending_results [$];
    t_out        next_want;
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    int          bytes_sent     = 0;
    int          burst_left;
    logic [7:0]  hdr_cur;
    string       field_name [10];
    t_dir_row    dir_rows [NUM_DIR_ROWS];

    int          ready_tick   = 0;
    int          ready_period = 1;
    int          ready_hold   = 0;

    command_packet_receiver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Reflected CRC-8, one byte folded in bit by bit
    function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) begin
            c = c[0] ? ((c ^ CRC_POLY) >> 1) : (c >> 1);
        end
        return c;
    endfunction

    // Close a packet on its CRC byte: judge the residue and the mode, then copy
    // the payload of an accepted packet into the held bytes it owns.
    function automatic logic [2:0] close_packet(logic [1:0] mode);
        logic panic;
        logic safe;
        panic = (mode == MODE_PANIC);
        safe  = (mode == MODE_SAFE);
        if (crc_acc != 8'h00) begin
            return EV_CRC_FAIL;
        end
        if (pkt_kind == KIND_MODE) begin
            if (panic) begin
                return EV_IGNORED;
            end
            held_val[0] = payload_buf[0];
            held_val[1] = payload_buf[1];
            return EV_MODE_OK;
        end
        if (panic || safe) begin
            return EV_IGNORED;
        end
        if (pkt_kind == KIND_GAIN) begin
            held_val[2] = payload_buf[0];
            held_val[3] = payload_buf[1];
            held_val[4] = payload_buf[2];
            return EV_GAIN_OK;
        end
        held_val[5] = payload_buf[0];
        held_val[6] = payload_buf[1];
        held_val[7] = payload_buf[2];
        held_val[8] = payload_buf[3];
        return EV_SET_OK;
    endfunction

    // Advance the receiver copy by one byte and return the result item
    function automatic t_out parse_byte(logic [7:0] b, logic [1:0] mode);
        t_out       res;
        logic [2:0] ev;
        logic [2:0] slot;
        ev = EV_NONE;
        if (rx_phase == PH_TYPE) begin
            if (b >= KIND_MODE && b <= KIND_SET) begin
                pkt_kind   = b[1:0];
                bytes_left = b[2:0] + 3'd2;
                crc_acc    = crc8_update(crc_acc, b);
                rx_phase   = PH_BODY;
            end else begin
                // a bad type byte is dropped, never taken as a new header
                ev       = EV_BAD_TYPE;
                rx_phase = PH_HUNT;
            end
        end else if (rx_phase == PH_BODY) begin
            slot    = {1'b0, pkt_kind} + 3'd2 - bytes_left;
            crc_acc = crc8_update(crc_acc, b);
            if (bytes_left > 3'd1) begin
                payload_buf[slot[1:0]] = b;
                bytes_left = bytes_left - 3'd1;
            end else begin
                bytes_left = 3'd0;
                ev       = close_packet(mode);
                rx_phase = PH_HUNT;
            end
        end else begin
            // hunting, and the unused phase code behaves the same
            rx_phase = PH_HUNT;
            if (b == hdr_model) begin
                crc_acc  = crc8_update(8'h00, b);
                rx_phase = PH_TYPE;
            end
        end
        res.event_res      = ev;
        res.mode_request   = held_val[0];
        res.toggle_request = held_val[1];
        res.gain_p         = held_val[2];
        res.gain_p1        = held_val[3];
        res.gain_p2        = held_val[4];
        res.yaw_target     = held_val[5];
        res.pitch_target   = held_val[6];
        res.roll_target    = held_val[7];
        res.lift_target    = held_val[8];
        return res;
    endfunction

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Compare one result item, field by field, with the oldest expectation
    function automatic void check_result(t_out got);
        t_out             want;
        logic [9:0][7:0]  g;
        logic [9:0][7:0]  w;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result item %0d arrived with none expected", results_seen));
            results_seen++;
            return;
        end
        want = pending_results.pop_front();
        g = {5'b0, got};
        w = {5'b0, want};
        for (int k = 9; k >= 0; k--) begin
            if (g[k] !== w[k]) begin
                report_mismatch($sformatf("result item %0d %s: expected %h, got %h",
                                          results_seen, field_name[k], w[k], g[k]));
            end
        end
        results_seen++;
    endfunction

    // Watch all three channels. Values read here are the ones before the
    // edge, so the order against the block's own updates does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                hdr_model = i_cfg_data;
            end
            if (o_out_valid && i_out_ready) begin
                check_result(o_out);
            end
            if (i_in_valid && o_in_ready) begin
                next_want = parse_byte(i_in.rx_byte, i_in.mode_class);
                if (drv_ev_known) begin
                    next_want.event_res = drv_ev;
                end
                pending_results.push_back(next_want);
            end
        end
    end

    // Receiver stalls: at the start of each stall window pick a new period and a
    // stall length within it; a stall length of zero gives a window with no stalls.
    always @(posedge i_clk) begin
        if (ready_tick % 256 == 0) begin
            ready_period = $urandom_range(1, 8);
            ready_hold   = $urandom_range(0, ready_period - 1);
        end
        i_out_ready <= (ready_tick % ready_period) >= ready_hold;
        ready_tick++;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Offer one item and hold it until taken. At the end of a burst drop
    // valid and idle before the next item, so valid never falls and rises
    // within the same step.
    task automatic send_byte(logic [7:0] b, logic [1:0] mode, logic known, logic [2:0] ev);
        i_in_valid       <= 1'b1;
        i_in.rx_byte     <= b;
        i_in.mode_class  <= mode;
        drv_ev_known     <= known;
        drv_ev           <= ev;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Send header and type; for a known type follow with the payload and a
    // CRC byte that is either the running CRC (zero residue) or one bit off.
    // With jitter set, every byte but the last carries a random mode class.
    task automatic send_packet(logic [7:0] ptype, logic [31:0] body, logic crc_good,
                               logic [1:0] last_mode, logic jitter, logic known,
                               logic [2:0] ev);
        logic [7:0] crc;
        logic [1:0] m;
        int         n;
        crc = crc8_update(8'h00, hdr_cur);
        m = jitter ? 2'($urandom_range(0, 3)) : last_mode;
        send_byte(hdr_cur, m, 1'b0, EV_NONE);
        if (!(ptype >= KIND_MODE && ptype <= KIND_SET)) begin
            send_byte(ptype, last_mode, known, ev);
            return;
        end
        m = jitter ? 2'($urandom_range(0, 3)) : last_mode;
        send_byte(ptype, m, 1'b0, EV_NONE);
        crc = crc8_update(crc, ptype);
        n = ptype + 1;
        for (int k = 0; k < n; k++) begin
            m = jitter ? 2'($urandom_range(0, 3)) : last_mode;
            send_byte(body[8*k +: 8], m, 1'b0, EV_NONE);
            crc = crc8_update(crc, body[8*k +: 8]);
        end
        if (!crc_good) begin
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        end
        send_byte(crc, last_mode, known, ev);
    endtask

    // Mostly packets of a known type with random content and mode, a tenth of
    // them with a bad CRC, the rest random types, line noise and packets cut short.
    task automatic random_traffic(int n_bytes);
        int         start;
        int         pick;
        int         cnt;
        logic [1:0] m;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            m = ($urandom_range(0, 9) < 6) ? MODE_NORMAL : 2'($urandom_range(1, 3));
            if (pick < 72) begin
                send_packet(8'($urandom_range(1, 3)), $urandom, $urandom_range(0, 9) != 0,
                            m, 1'b1, 1'b0, EV_NONE);
            end else if (pick < 80) begin
                send_packet(8'($urandom_range(0, 255)), $urandom, 1'b1, m, 1'b1, 1'b0,
                            EV_NONE);
            end else if (pick < 92) begin
                cnt = $urandom_range(1, 4);
                repeat (cnt) send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                                       1'b0, EV_NONE);
            end else begin
                // header and type, then a few bytes and cut off
                send_byte(hdr_cur, m, 1'b0, EV_NONE);
                send_byte(8'($urandom_range(1, 3)), m, 1'b0, EV_NONE);
                cnt = $urandom_range(0, 3);
                repeat (cnt) send_byte(8'($urandom_range(0, 255)), m, 1'b0, EV_NONE);
            end
        end
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    task automatic write_header(logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hdr_cur = value;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 8'h00;
        drv_ev_known = 1'b0;
        drv_ev       = EV_NONE;

        hdr_model  = 8'h00;
        rx_phase   = PH_HUNT;
        pkt_kind   = 2'd0;
        bytes_left = 3'd0;
        crc_acc    = 8'h00;
        for (int k = 0; k < 4; k++) payload_buf[k] = 8'h00;
        for (int k = 0; k < 9; k++) held_val[k] = 8'h00;
        hdr_cur    = 8'h00;
        burst_left = $urandom_range(1, 16);

        field_name = '{"lift_target", "roll_target", "pitch_target", "yaw_target",
                       "gain_p2", "gain_p1", "gain_p", "toggle_request",
                       "mode_request", "event_res"};

        // Directed rows, run with the header still at its reset value 0
        dir_rows = '{
            // noise while hunting is dropped
            '{1'b1, 8'h55,      32'h0000_0000, 1'b0, MODE_NORMAL, EV_NONE},
            // type byte equal to the header: bad type, not a new header
            '{1'b0, 8'h00,      32'h0000_0000, 1'b0, MODE_NORMAL, EV_BAD_TYPE},
            // mode packet under the spare mode class, which acts as normal
            '{1'b0, 8'(KIND_MODE), 32'h0000_FF00, 1'b1, MODE_SPARE, EV_MODE_OK},
            '{1'b0, 8'(KIND_GAIN), 32'h00FF_00FF, 1'b1, MODE_NORMAL, EV_GAIN_OK},
            '{1'b0, 8'(KIND_SET),  32'h00FF_00FF, 1'b1, MODE_NORMAL, EV_SET_OK},
            // good mode packet in panic
            '{1'b0, 8'(KIND_MODE), 32'h0000_A55A, 1'b1, MODE_PANIC, EV_IGNORED},
            // bad CRC wins over the mode check
            '{1'b0, 8'(KIND_GAIN), 32'h0012_3456, 1'b0, MODE_SAFE, EV_CRC_FAIL},
            '{1'b0, 8'hFF,      32'h0000_0000, 1'b0, MODE_NORMAL, EV_BAD_TYPE}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIR_ROWS; r++) begin
            if (dir_rows[r].is_noise) begin
                send_byte(dir_rows[r].lead, dir_rows[r].mode, 1'b1, dir_rows[r].ev);
            end else begin
                send_packet(dir_rows[r].lead, dir_rows[r].body, dir_rows[r].crc_good,
                            dir_rows[r].mode, 1'b0, 1'b1, dir_rows[r].ev);
            end
        end

        // Random phases, each under its own header byte, extremes first
        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: write_header(8'hFF);
                1: write_header(8'h00);
                default: write_header(8'($urandom_range(0, 255)));
            endcase
            random_traffic(BYTES_PER_PHASE);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
